// ===== rtl/sm3_pkg.sv =====
// sm3_pkg: constants, types and round helper functions for the sm3 hash block
// no dependencies

package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [255:0] SM3_IV = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for a message word
      ST_PAD,    // inserting padding or length words
      ST_ROUND,  // running 64 rounds
      ST_OUT     // delivering the digest
   } state_type;

   function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
   endfunction

endpackage

// ===== rtl/sm3_if.sv =====
// sm3_if: valid/ready channel interfaces for message words and digest words
// depends on nothing

interface sm3_req_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        final_word;
   modport source (output valid, message_word, valid_bytes, final_word, input ready);
   modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sm3_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;
   modport source (output valid, digest_word, digest_last, input ready);
   modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ===== rtl/sm3_hash.sv =====
// sm3_hash: sm3 256-bit hash engine, one round per cycle on a sliding window
// depends on sm3_pkg and sm3_if
//
// usage
//   req: 32-bit big-endian message words, valid_bytes and final_word.
//   rsp: eight digest words, most significant first, digest_last on the eighth.
//   a word is taken whenever valid is high while idle; the 16th word of a block starts 64
//   rounds, one round per cycle through the shared round datapath with a
//   16-word message window that expands w[j+16] as it slides. a sustained
//   stream alternates taking a block's 16 words and running its 64 rounds.
//   a final word adds padding words one per cycle (up to 15, and one more
//   block of up to 16 words plus 64 rounds if the length does not fit), then
//   8 digest transfers, one per cycle when rsp_ready is high.
//   req ready is low while padding, compressing or delivering; a stalled
//   receiver simply holds the current digest word.
//   reset loads the initial value, clears word count and length; the digest
//   returns to the initial value after each message.

module sm3_hash
   import sm3_pkg::*;
(
   input logic clock,
   input logic reset,
   sm3_req_if.sink req,
   sm3_rsp_if.source rsp
);

   state_type   state_ff, state_in;
   logic [255:0] cv_ff, cv_in;
   logic [255:0] work_ff, work_in;
   logic [511:0] win_ff, win_in;
   logic [3:0]  widx_ff, widx_in;
   logic [60:0] blen_ff, blen_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        fin_ff, fin_in;     // message ended, padding in progress
   logic [3:0]  padn_ff, padn_in;   // 15: pad word owed, 1: low length word owed
   logic        lenhi_ff, lenhi_in; // length words pending

   logic        push;
   logic [31:0] push_word;
   logic [2:0]  nvalid;
   logic [31:0] keep, last_word;
   logic [63:0] bits;

   // round datapath
   logic [31:0] a, b, c, d, e, f, g, h, wj, wpj, tj, a12, ss1, ss2, ff1, gg1, tt1, tt2;
   logic [31:0] wnew;

   assign nvalid = (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
   assign keep = (nvalid == 3'd0) ? 32'h0 : ~(32'hffffffff >> {nvalid, 3'b000});
   assign last_word = (req.message_word & keep) |
                      ({24'h0, PAD_BYTE} << (6'd24 - {nvalid, 3'b000}));
   assign bits = {blen_ff, 3'b000};

   assign {a, b, c, d, e, f, g, h} = work_ff;
   assign wj  = win_ff[511:480];
   assign wpj = wj ^ win_ff[383:352];
   assign tj  = (rnd_ff < 6'd16) ? T_LOW : T_HIGH;
   assign a12 = rol32(a, 5'd12);
   assign ss1 = rol32(a12 + e + rol32(tj, rnd_ff[4:0]), 5'd7);
   assign ss2 = ss1 ^ a12;
   assign ff1 = (rnd_ff < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
   assign gg1 = (rnd_ff < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
   assign tt1 = ff1 + d + ss2 + wpj;
   assign tt2 = gg1 + h + ss1 + wj;
   // w[j+16] from the window w[j..j+15]
   assign wnew = perm1(win_ff[511:480] ^ win_ff[287:256] ^ rol32(win_ff[95:64], 5'd15))
               ^ rol32(win_ff[415:384], 5'd7) ^ win_ff[191:160];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (widx_ff == 4'd15) state_in = ST_ROUND;
               else if (req.final_word) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (widx_ff == 4'd15) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) state_in = fin_ff ? ST_PAD : ST_IDLE;
            if (rnd_ff == 6'd63 && fin_ff && !lenhi_ff && padn_ff == 4'd0)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // word push source
   always_comb begin
      push = 1'b0;
      push_word = 32'h0;
      fin_in = fin_ff;
      padn_in = padn_ff;
      lenhi_in = lenhi_ff;
      blen_in = blen_ff;
      if (state_ff == ST_IDLE && req.valid) begin
         push = 1'b1;
         if (!req.final_word) begin
            push_word = req.message_word;
            blen_in = blen_ff + 61'd4;
         end else begin
            fin_in = 1'b1;
            lenhi_in = 1'b1;
            blen_in = blen_ff + {58'h0, nvalid};
            if (nvalid == 3'd4) begin
               push_word = req.message_word;
               padn_in = 4'd15;   // marker: pad word still owed
            end else begin
               push_word = last_word;
               padn_in = 4'd0;
            end
         end
      end else if (state_ff == ST_PAD) begin
         push = 1'b1;
         if (padn_ff == 4'd15) begin
            push_word = PAD_WORD;
            padn_in = 4'd0;
         end else if (widx_ff == 4'd14 && lenhi_ff) begin
            push_word = bits[63:32];
            padn_in = 4'd1;   // marker: low length word follows
         end else if (widx_ff == 4'd15 && lenhi_ff && padn_ff == 4'd1) begin
            push_word = bits[31:0];
            lenhi_in = 1'b0;
            padn_in = 4'd0;
         end else begin
            push_word = 32'h0;
         end
      end
   end

   // datapath registers
   always_comb begin
      cv_in = cv_ff;
      work_in = work_ff;
      win_in = win_ff;
      widx_in = widx_ff;
      rnd_in = rnd_ff;
      oidx_in = oidx_ff;
      if (push) begin
         win_in = {win_ff[479:0], push_word};
         widx_in = widx_ff + 4'd1;
         if (widx_ff == 4'd15) begin
            work_in = cv_ff;
            rnd_in = 6'd0;
         end
      end
      if (state_ff == ST_ROUND) begin
         work_in = {tt1, a, rol32(b, 5'd9), c, perm0(tt2), e, rol32(f, 5'd19), g};
         win_in = {win_ff[479:0], wnew};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            cv_in = cv_ff ^ work_in;
            oidx_in = 3'd0;
         end
      end
      if (state_ff == ST_OUT && rsp.ready) begin
         oidx_in = oidx_ff + 3'd1;
         if (oidx_ff == 3'd7) cv_in = SM3_IV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cv_ff <= SM3_IV;
         widx_ff <= 4'd0;
         blen_ff <= 61'd0;
         rnd_ff <= 6'd0;
         oidx_ff <= 3'd0;
         fin_ff <= 1'b0;
         padn_ff <= 4'd0;
         lenhi_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cv_ff <= cv_in;
         widx_ff <= widx_in;
         blen_ff <= (state_in == ST_IDLE && state_ff == ST_OUT) ? 61'd0 : blen_in;
         rnd_ff <= rnd_in;
         oidx_ff <= oidx_in;
         fin_ff <= (state_ff == ST_OUT) ? 1'b0 : fin_in;
         padn_ff <= padn_in;
         lenhi_ff <= lenhi_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      win_ff <= win_in;
   end

   // outputs
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_OUT);
      rsp.digest_word = cv_ff[255 - {oidx_ff, 5'b00000} -: 32];
      rsp.digest_last = (oidx_ff == 3'd7);
   end

   // checks
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("req ready during digest output");
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd0) |-> widx_ff == 4'd0)
      else $error("rounds started on partial block");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(oidx_ff))
      else $error("digest index moved during stall");

endmodule

// ===== tb/sv/sm3_checker.sv =====
// sm3_checker: watches the message and digest channels, predicts the sm3 digest
// depends on sm3_if (channel interfaces); the hash math is its own

module sm3_checker (
   input logic clock,
   input logic reset,
   sm3_req_if.sink req_mon,
   sm3_rsp_if.sink rsp_mon,
   output int fail_count,
   output int pending_count,
   output int digest_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] HASH_IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   logic [31:0] chain [8];
   logic [31:0] blk [16];
   int unsigned slot;
   logic [60:0] msg_bytes;
   digest_beat_type digest_q [$];

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      int k;
      k = n % 32;
      if (k == 0) return x;
      return (x << k) | (x >> (32 - k));
   endfunction

   // one block compression into the chaining value
   task automatic compress();
      logic [31:0] w [68];
      logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2, x;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++) begin
         x = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
         w[j] = (x ^ rotl(x, 15) ^ rotl(x, 23)) ^ rotl(w[j-13], 7) ^ w[j-6];
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int j = 0; j < 64; j++) begin
         tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
         a12 = rotl(a, 12);
         ss1 = rotl(a12 + e + rotl(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rotl(b, 9); b = a; a = tt1;
         h = g; g = rotl(f, 19); f = e; e = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
   endtask

   task automatic push_word(input logic [31:0] v);
      blk[slot] = v;
      slot = (slot + 1) % 16;
      if (slot == 0) compress();
   endtask

   // absorb one accepted message word, queue a digest on the final one
   task automatic absorb(input logic [31:0] msg, input logic [2:0] vb, input logic fin);
      int n;
      logic [31:0] keep;
      logic [63:0] bits;
      n = (vb > 3'd4) ? 4 : int'(vb);
      if (!fin) begin
         msg_bytes = msg_bytes + 61'd4;
         push_word(msg);
         return;
      end
      msg_bytes = msg_bytes + 61'(n);
      if (n == 4) begin
         push_word(msg);
         push_word(32'h80000000);
      end else begin
         keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
         push_word((msg & keep) | (32'h80 << (24 - 8 * n)));
      end
      while (slot != 14) push_word(32'h0);
      bits = {msg_bytes, 3'b000};
      push_word(bits[63:32]);
      push_word(bits[31:0]);
      for (int k = 0; k < 8; k++) digest_q.insert(digest_q.size(), '{chain[k], k == 7});
      chain = HASH_IV;
      slot = 0;
      msg_bytes = '0;
   endtask

   // sample both channels at the edge
   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (reset) begin
         chain = HASH_IV;
         slot = 0;
         msg_bytes = '0;
         digest_q.delete();
         fail_count = 0;
         digest_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            digest_count++;
            if (digest_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected digest transfer %h last %b", $time,
                        rsp_mon.digest_word, rsp_mon.digest_last);
            end else begin
               exp_beat = digest_q.pop_front();
               if (rsp_mon.digest_word !== exp_beat.word) begin
                  fail_count++;
                  $display("%0t: digest_word expected %h actual %h", $time,
                           exp_beat.word, rsp_mon.digest_word);
               end
               if (rsp_mon.digest_last !== exp_beat.last) begin
                  fail_count++;
                  $display("%0t: digest_last expected %b actual %b", $time,
                           exp_beat.last, rsp_mon.digest_last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb(req_mon.message_word, req_mon.valid_bytes, req_mon.final_word);
      end
      pending_count = digest_q.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      digest_count = 0;
   end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus, receiver stalls and verdict for the sm3_hash block
// depends on sm3_pkg, sm3_if, sm3_hash and sm3_checker

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending_count, digest_count;
   int word_count = 0;
   int msg_count = 0;
   bit rsp_hold = 1'b0;
   bit rsp_calm = 1'b0;
   bit req_calm = 1'b0;

   sm3_req_if req_ch (clock);
   sm3_rsp_if rsp_ch (clock);

   sm3_hash u_top (.clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source));

   sm3_checker u_checker (.clock(clock), .reset(reset), .req_mon(req_ch.sink),
      .rsp_mon(rsp_ch.sink), .fail_count(fail_count), .pending_count(pending_count),
      .digest_count(digest_count));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.message_word = '0;
      req_ch.valid_bytes = '0;
      req_ch.final_word = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // receiver: random stalls, a calm stretch and a long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (rsp_hold) rsp_ch.ready <= 1'b0;
      else if (rsp_calm) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(99) >= 29);
   end

   // offer one word and hold it until the transfer
   task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic fin);
      while (!req_calm && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.message_word <= w;
      req_ch.valid_bytes <= vb;
      req_ch.final_word <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      word_count++;
      if (fin) msg_count++;
   endtask

   // a message of nfull words then a final word with fvb bytes
   task automatic send_msg(input int nfull, input logic [2:0] fvb);
      for (int i = 0; i < nfull; i++) send_word($urandom, 3'($urandom_range(7)), 1'b0);
      send_word($urandom, fvb, 1'b1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extreme words, each valid count, block boundaries
      send_word(32'h0, 3'd0, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      send_word(32'hffffffff, 3'd1, 1'b1);
      send_word(32'hffffffff, 3'd2, 1'b1);
      send_word(32'hffffffff, 3'd3, 1'b1);
      send_word(32'h61626300, 3'd7, 1'b1);
      send_word(32'h12345678, 3'd5, 1'b0);
      send_word(32'h9abcdef0, 3'd6, 1'b1);
      send_msg(12, 3'd4);
      send_msg(13, 3'd2);
      send_msg(15, 3'd0);
      send_msg(15, 3'd4);
      // sender pause until every digest word is back
      drain();
      // receiver holds off while messages keep coming
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            send_msg(2, 3'd3);
            send_msg(0, 3'd4);
            send_msg(1, 3'd1);
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      join
      // calm stretch: no idling on either side
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      send_msg(20, 3'd3);
      send_msg(6, 3'd2);
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      // random messages, mostly short
      while (word_count < 120) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
         send_msg(n, 3'($urandom_range(7)));
      end
      drain();
      $display("covered %0d words in %0d messages, %0d digest words checked",
               word_count, msg_count, digest_count);
      if (fail_count == 0 && pending_count == 0) $display("sm3_hash verification clean");
      else $display("sm3_hash verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("sm3_hash verification failed");
      $finish;
   end

endmodule

// ===== sm3_hash.f =====
rtl/sm3_pkg.sv
rtl/sm3_if.sv
rtl/sm3_hash.sv
tb/sv/sm3_checker.sv
tb/sv/tb.sv
